### rtl/deadline_ordered_timer_table_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the deadline ordered timer table
// Clocked, reset-qualified implication forms.
// ----------------------------------------------------------------------------
`ifndef DEADLINE_ORDERED_TIMER_TABLE_UNIT_MACROS_SVH
`define DEADLINE_ORDERED_TIMER_TABLE_UNIT_MACROS_SVH

// same-cycle implication
`define DOTU_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DOTU_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/dotu_pkg.sv
// ----------------------------------------------------------------------------
// dotu_pkg
// Opcodes, status codes, constants and shared types of the timer table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dotu_pkg;

	localparam logic [2:0] OP_ADD     = 3'd0;
	localparam logic [2:0] OP_CANCEL  = 3'd1;
	localparam logic [2:0] OP_REFRESH = 3'd2;
	localparam logic [2:0] OP_RESET   = 3'd3;
	localparam logic [2:0] OP_COLLECT = 3'd4;
	localparam logic [2:0] OP_QUERY   = 3'd5;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	localparam logic [2:0] ADDR_WINDOW = 3'd0;

	localparam int NUM_SLOTS   = 16;
	localparam int MAX_RESULTS = 16;
	localparam int RES_CNT_W   = 5;
	localparam int ORD_IW      = 4;

	localparam int PER_W  = 32;
	localparam int DL_W   = 64;
	localparam int WORD_W = PER_W + DL_W;

	localparam logic [31:0] WINDOW_RESET = 32'd3600000;
	localparam logic [63:0] ALL_ONES     = 64'hFFFF_FFFF_FFFF_FFFF;

	typedef struct packed {
		logic [63:0] a;
		logic [63:0] b;
		logic        sub;
	} alu_req_t;

	typedef struct packed {
		logic [63:0] res;
		logic        borrow;
	} alu_rsp_t;

endpackage

### rtl/dotu_ram.sv
// ----------------------------------------------------------------------------
// dotu_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dotu_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/dotu_alu.sv
// ----------------------------------------------------------------------------
// dotu_alu
// Shared 64-bit add/subtract unit with borrow out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dotu_alu (
	input  dotu_pkg::alu_req_t req,
	output dotu_pkg::alu_rsp_t rsp
);

	logic [64:0] sum;

	assign sum = {1'b0, req.a} + {1'b0, (req.sub ? ~req.b : req.b)} + 65'(req.sub);
	assign rsp.res    = sum[63:0];
	assign rsp.borrow = req.sub & ~sum[64];

endmodule

### rtl/deadline_ordered_timer_table_unit.sv
// ----------------------------------------------------------------------------
// deadline_ordered_timer_table_unit
// Timer slot table ordered by deadline, with one shared adder and a sequencer.
// ----------------------------------------------------------------------------
// Commands arrive on the cmd channel (cmd_valid / cmd_stall), one transfer per
// command, each carrying now_ms. Results leave on the rsp channel (rsp_valid /
// rsp_stall); every command gives one result, collect gives one per expired
// slot, and the final result of a command has last set.
// The block takes one command at a time; cmd_stall is high while a command is
// at work. Slot periods and deadlines sit in one RAM that is scanned one slot
// per cycle. Cancel, refresh and undefined opcodes need no scan. Query, add
// to a table that is not full and a reset that changes a live slot scan the
// table once; a failed add and a reset that changes nothing need no scan.
// Collect needs no scan on an empty table; else it scans once per expired
// slot and, unless it has taken 16, once more to find that none is left.
// The block idles before the next command is taken. The result register
// lets a new command be taken while a result waits; a stalled receiver holds
// the result and, once the sequencer needs the result register again, holds
// the sequencer. Reset clears all slots, the notice and the previous time, and
// loads the rollover window with its default.
// rollover_window_ms lies at APB byte address 0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module deadline_ordered_timer_table_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  logic [2:0]  opcode,
	input  logic [3:0]  slot,
	input  logic [31:0] period_ms,
	input  logic        recurring,
	input  logic        restart_now,
	input  logic [63:0] now_ms,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [1:0]  status,
	output logic [3:0]  result_slot,
	output logic        expired_valid,
	output logic [63:0] time_to_next,
	output logic        front_notice,
	output logic        any_active,
	output logic        last
);

	localparam int NUM_SLOTS = dotu_pkg::NUM_SLOTS;
	localparam int IW = $clog2(NUM_SLOTS);
	localparam logic [IW-1:0] LAST_IX = IW'(NUM_SLOTS - 1);

	typedef enum logic [10:0] {
		S_IDLE      = 11'b000_0000_0001,
		S_DECODE    = 11'b000_0000_0010,
		S_ADD_WR    = 11'b000_0000_0100,
		S_RD        = 11'b000_0000_1000,
		S_RST2      = 11'b000_0001_0000,
		S_ROLL      = 11'b000_0010_0000,
		S_SCAN      = 11'b000_0100_0000,
		S_SCAN_FIN  = 11'b000_1000_0000,
		S_SCAN_DONE = 11'b001_0000_0000,
		S_EMIT      = 11'b010_0000_0000,
		S_RESP      = 11'b100_0000_0000
	} state_t;

	typedef enum logic [2:0] {
		M_FRONT   = 3'b001,
		M_QUERY   = 3'b010,
		M_COLLECT = 3'b100
	} mode_t;

	state_t state_q;
	mode_t  mode_q;

	logic [NUM_SLOTS-1:0] active_q, recur_q, taken_q;
	logic [63:0] prev_q;
	logic        notice_q;
	logic [31:0] window_q;
	logic        roll_q;
	logic [IW-1:0] sc_q, tgt_q;
	logic        v_s1;
	logic [IW-1:0] ix_s1;
	logic [dotu_pkg::RES_CNT_W-1:0] n_q;
	logic [dotu_pkg::ORD_IW-1:0]    em_q;
	logic        best_found_q;

	logic [2:0]  op_q;
	logic [3:0]  slot_q;
	logic [31:0] per_q;
	logic        rec_q, fromnow_q;
	logic [63:0] now_q, start_q;
	logic [IW-1:0] best_ix_q;
	logic [63:0] best_dl_q;
	logic [31:0] best_per_q;
	logic [IW-1:0] order_q [dotu_pkg::MAX_RESULTS];
	logic [1:0]  res_st_q;
	logic [3:0]  res_slot_q;
	logic        res_fn_q;
	logic [63:0] res_ttn_q;

	logic [1:0]  status_q;
	logic [3:0]  result_slot_q;
	logic        expired_q, fn_q, any_q, last_q, rsp_valid_q;
	logic [63:0] ttn_q;

	logic                         ram_we;
	logic [IW-1:0]                ram_waddr, ram_raddr;
	logic [dotu_pkg::WORD_W-1:0]  ram_wdata, ram_rdata;
	logic [31:0]                  rd_per;
	logic [63:0]                  rd_dl;
	dotu_pkg::alu_req_t           alu_req;
	dotu_pkg::alu_rsp_t           alu_rsp;

	logic [IW-1:0] slot_ix, free_ix;
	logic          slot_ok, all_full, rsp_free, emit_last, rst_same;
	logic          elig, better;

	dotu_ram #(.WIDTH(dotu_pkg::WORD_W), .DEPTH(NUM_SLOTS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	dotu_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	assign rd_per   = ram_rdata[dotu_pkg::WORD_W-1:dotu_pkg::DL_W];
	assign rd_dl    = ram_rdata[dotu_pkg::DL_W-1:0];
	assign slot_ix  = IW'(slot_q);
	assign slot_ok  = 32'(slot_q) < 32'(NUM_SLOTS);
	assign all_full = &active_q;
	assign rsp_free = !rsp_valid_q || !rsp_stall;
	assign emit_last = ({1'b0, em_q} + 5'd1) == n_q;
	assign rst_same = (per_q == rd_per) && !fromnow_q;

	always_comb begin
		free_ix = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (!active_q[i]) begin
				free_ix = IW'(i);
			end
		end
	end

	assign elig = active_q[ix_s1] && !(mode_q == M_COLLECT &&
		(taken_q[ix_s1] || (!roll_q && rd_dl > now_q)));
	assign better = !best_found_q || (rd_dl < best_dl_q);

	always_comb begin
		ram_raddr   = sc_q;
		ram_we      = 1'b0;
		ram_waddr   = tgt_q;
		alu_req.a   = now_q;
		alu_req.b   = {32'd0, per_q};
		alu_req.sub = 1'b0;
		ram_wdata   = {per_q, alu_rsp.res};
		case (state_q)
			S_DECODE: begin
				ram_raddr = slot_ix;
			end
			S_ADD_WR: begin
				ram_we = 1'b1;
			end
			S_RD: begin
				if (op_q == dotu_pkg::OP_REFRESH) begin
					alu_req.b = {32'd0, rd_per};
					ram_wdata = {rd_per, alu_rsp.res};
					ram_we    = 1'b1;
				end else if (!rst_same && active_q[tgt_q]) begin
					if (fromnow_q) begin
						ram_we = 1'b1;
					end else begin
						alu_req.a   = rd_dl;
						alu_req.b   = {32'd0, rd_per};
						alu_req.sub = 1'b1;
					end
				end
			end
			S_RST2: begin
				alu_req.a = start_q;
				ram_we    = 1'b1;
			end
			S_ROLL: begin
				alu_req.a   = prev_q;
				alu_req.b   = now_q;
				alu_req.sub = 1'b1;
			end
			S_SCAN_DONE: begin
				if (mode_q == M_QUERY) begin
					alu_req.a   = best_dl_q;
					alu_req.b   = now_q;
					alu_req.sub = 1'b1;
				end else if (mode_q == M_COLLECT) begin
					alu_req.b = {32'd0, best_per_q};
					ram_waddr = best_ix_q;
					ram_wdata = {best_per_q, alu_rsp.res};
					ram_we    = best_found_q && recur_q[best_ix_q];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			mode_q       <= M_FRONT;
			active_q     <= '0;
			recur_q      <= '0;
			taken_q      <= '0;
			prev_q       <= '0;
			notice_q     <= 1'b0;
			window_q     <= dotu_pkg::WINDOW_RESET;
			roll_q       <= 1'b0;
			sc_q         <= '0;
			tgt_q        <= '0;
			v_s1         <= 1'b0;
			ix_s1        <= '0;
			n_q          <= '0;
			em_q         <= '0;
			best_found_q <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (psel && penable && pwrite && paddr == dotu_pkg::ADDR_WINDOW) begin
				window_q <= pwdata;
			end
			v_s1  <= (state_q == S_SCAN);
			ix_s1 <= sc_q;
			if (state_q == S_SCAN && sc_q == '0) begin
				best_found_q <= 1'b0;
			end else if (v_s1 && elig && better) begin
				best_found_q <= 1'b1;
			end
			if ((state_q == S_RESP || state_q == S_EMIT) && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					sc_q    <= '0;
					state_q <= S_RESP;
					case (op_q)
						dotu_pkg::OP_ADD: begin
							if (!all_full) begin
								tgt_q   <= free_ix;
								mode_q  <= M_FRONT;
								state_q <= S_ADD_WR;
							end
						end
						dotu_pkg::OP_CANCEL: begin
							if (slot_ok && active_q[slot_ix]) begin
								active_q[slot_ix] <= 1'b0;
							end
						end
						dotu_pkg::OP_REFRESH: begin
							if (slot_ok && active_q[slot_ix]) begin
								tgt_q   <= slot_ix;
								state_q <= S_RD;
							end
						end
						dotu_pkg::OP_RESET: begin
							if (slot_ok) begin
								tgt_q   <= slot_ix;
								mode_q  <= M_FRONT;
								state_q <= S_RD;
							end
						end
						dotu_pkg::OP_COLLECT: begin
							if (|active_q) begin
								mode_q  <= M_COLLECT;
								state_q <= S_ROLL;
							end
						end
						dotu_pkg::OP_QUERY: begin
							notice_q <= 1'b0;
							mode_q   <= M_QUERY;
							state_q  <= S_SCAN;
						end
						default: begin
						end
					endcase
				end
				S_ADD_WR: begin
					active_q[tgt_q] <= 1'b1;
					recur_q[tgt_q]  <= rec_q;
					state_q         <= S_SCAN;
				end
				S_RD: begin
					state_q <= S_RESP;
					if (op_q == dotu_pkg::OP_RESET && !rst_same && active_q[tgt_q]) begin
						state_q <= fromnow_q ? S_SCAN : S_RST2;
					end
				end
				S_RST2: begin
					state_q <= S_SCAN;
				end
				S_ROLL: begin
					roll_q  <= !alu_rsp.borrow && (alu_rsp.res > {32'd0, window_q});
					prev_q  <= now_q;
					taken_q <= '0;
					n_q     <= '0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					sc_q <= sc_q + 1'b1;
					if (sc_q == LAST_IX) begin
						state_q <= S_SCAN_FIN;
					end
				end
				S_SCAN_FIN: begin
					state_q <= S_SCAN_DONE;
				end
				S_SCAN_DONE: begin
					sc_q    <= '0;
					state_q <= S_RESP;
					if (mode_q == M_FRONT) begin
						if (best_found_q && best_ix_q == tgt_q && !notice_q) begin
							notice_q <= 1'b1;
						end
					end else if (mode_q == M_COLLECT) begin
						em_q <= '0;
						if (best_found_q) begin
							taken_q[best_ix_q] <= 1'b1;
							n_q                <= n_q + 1'b1;
							if (!recur_q[best_ix_q]) begin
								active_q[best_ix_q] <= 1'b0;
							end
							if (n_q == 5'(dotu_pkg::MAX_RESULTS - 1)) begin
								state_q <= S_EMIT;
							end else begin
								state_q <= S_SCAN;
							end
						end else if (n_q != '0) begin
							state_q <= S_EMIT;
						end
					end
				end
				S_EMIT: begin
					if (rsp_free) begin
						em_q <= em_q + 1'b1;
						if (emit_last) begin
							state_q <= S_IDLE;
						end
					end
				end
				S_RESP: begin
					if (rsp_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && cmd_valid) begin
			op_q      <= opcode;
			slot_q    <= slot;
			per_q     <= period_ms;
			rec_q     <= recurring;
			fromnow_q <= restart_now;
			now_q     <= now_ms;
		end
		if (v_s1 && elig && better) begin
			best_ix_q  <= ix_s1;
			best_dl_q  <= rd_dl;
			best_per_q <= rd_per;
		end
		case (state_q)
			S_DECODE: begin
				res_st_q   <= dotu_pkg::ST_OK;
				res_slot_q <= '0;
				res_fn_q   <= 1'b0;
				res_ttn_q  <= '0;
				case (op_q)
					dotu_pkg::OP_ADD: begin
						if (all_full) begin
							res_st_q <= dotu_pkg::ST_FULL;
						end else begin
							res_slot_q <= 4'(free_ix);
						end
					end
					dotu_pkg::OP_CANCEL, dotu_pkg::OP_REFRESH: begin
						if (!(slot_ok && active_q[slot_ix])) begin
							res_st_q <= dotu_pkg::ST_MISS;
						end
					end
					dotu_pkg::OP_RESET: begin
						if (!slot_ok) begin
							res_st_q <= dotu_pkg::ST_MISS;
						end
					end
					default: begin
					end
				endcase
			end
			S_RD: begin
				start_q <= alu_rsp.res;
				if (op_q == dotu_pkg::OP_RESET && !rst_same && !active_q[tgt_q]) begin
					res_st_q <= dotu_pkg::ST_MISS;
				end
			end
			S_SCAN_DONE: begin
				if (mode_q == M_FRONT) begin
					res_fn_q <= best_found_q && best_ix_q == tgt_q && !notice_q;
				end else if (mode_q == M_QUERY) begin
					if (!best_found_q) begin
						res_ttn_q <= dotu_pkg::ALL_ONES;
					end else if (alu_rsp.borrow) begin
						res_ttn_q <= '0;
					end else begin
						res_ttn_q <= alu_rsp.res;
					end
				end else if (best_found_q) begin
					order_q[n_q[dotu_pkg::ORD_IW-1:0]] <= best_ix_q;
				end
			end
			default: begin
			end
		endcase
		if (state_q == S_RESP && rsp_free) begin
			status_q      <= res_st_q;
			result_slot_q <= res_slot_q;
			expired_q     <= 1'b0;
			ttn_q         <= res_ttn_q;
			fn_q          <= res_fn_q;
			any_q         <= |active_q;
			last_q        <= 1'b1;
		end else if (state_q == S_EMIT && rsp_free) begin
			status_q      <= dotu_pkg::ST_OK;
			result_slot_q <= 4'(order_q[em_q]);
			expired_q     <= 1'b1;
			ttn_q         <= '0;
			fn_q          <= 1'b0;
			any_q         <= |active_q;
			last_q        <= emit_last;
		end
	end

	assign cmd_stall     = (state_q != S_IDLE);
	assign rsp_valid     = rsp_valid_q;
	assign status        = status_q;
	assign result_slot   = result_slot_q;
	assign expired_valid = expired_q;
	assign time_to_next  = ttn_q;
	assign front_notice  = fn_q;
	assign any_active    = any_q;
	assign last          = last_q;
	assign pready        = 1'b1;
	assign prdata        = (paddr == dotu_pkg::ADDR_WINDOW) ? window_q : 32'd0;

endmodule

### rtl/dotu_checker.sv
// ----------------------------------------------------------------------------
// dotu_checker
// Port-level checks of the timer table result channel, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "deadline_ordered_timer_table_unit_macros.svh"

module dotu_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       rsp_valid,
	input logic       rsp_stall,
	input logic [1:0] status,
	input logic [3:0] result_slot,
	input logic       expired_valid,
	input logic       any_active,
	input logic       last
);

	`DOTU_ASSERT_NXT(a_hold, rsp_valid && rsp_stall, rsp_valid && $stable(result_slot) && $stable(status), "stalled transfer changed")
	`DOTU_ASSERT_IMP(a_exp_ok, rsp_valid && expired_valid, status == dotu_pkg::ST_OK, "expired result with error status")
	`DOTU_ASSERT_IMP(a_mid_exp, rsp_valid && !last, expired_valid, "non-final result is not an expiry")
	`DOTU_ASSERT_IMP(a_full, rsp_valid && status == dotu_pkg::ST_FULL, any_active && !expired_valid, "full status with empty table")

endmodule

bind deadline_ordered_timer_table_unit dotu_checker u_dotu_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.rsp_valid     (rsp_valid),
	.rsp_stall     (rsp_stall),
	.status        (status),
	.result_slot   (result_slot),
	.expired_valid (expired_valid),
	.any_active    (any_active),
	.last          (last)
);

### test/tb.sv
// ----------------------------------------------------------------------------
// tb - deadline ordered timer table testbench
// Drives directed and random timer commands through the cmd channel, checks
// every rsp transfer field by field against a cycle-free model of the slot
// table, and sweeps the rollover window and the idle pattern of both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

	typedef struct packed {
		logic [2:0]  op;
		logic [3:0]  slot;
		logic [31:0] per;
		logic        rec;
		logic        fnow;
		logic [63:0] now;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  rslot;
		logic        ev;
		logic [63:0] ttn;
		logic        fnote;
		logic        any;
		logic        last;
	} res_t;

	localparam int NSLOT = dotu_pkg::NUM_SLOTS;
	localparam int STALL_LIMIT = 20000;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        psel = 0, penable = 0, pwrite = 0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        cmd_valid = 0;
	logic        cmd_stall;
	logic [2:0]  opcode = '0;
	logic [3:0]  slot = '0;
	logic [31:0] period_ms = '0;
	logic        recurring = 0, restart_now = 0;
	logic [63:0] now_ms = '0;
	logic        rsp_valid;
	logic        rsp_stall = 0;
	logic [1:0]  status;
	logic [3:0]  result_slot;
	logic        expired_valid;
	logic [63:0] time_to_next;
	logic        front_notice, any_active, last;

	deadline_ordered_timer_table_unit u_top (.*);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	// table model
	logic        t_act [NSLOT];
	logic        t_rec [NSLOT];
	logic        t_wr  [NSLOT];
	logic [31:0] t_per [NSLOT];
	logic [63:0] t_dl  [NSLOT];
	logic [63:0] t_prev = '0;
	logic        t_notice = 0;
	logic [31:0] t_window = dotu_pkg::WINDOW_RESET;

	cmd_t pend_cmds[$];
	res_t want_rsp[$];
	cmd_t cur;
	int   send_idle = 0, recv_idle = 0;
	int   n_cmds = 0, n_rsp = 0, n_expired = 0, n_bad = 0, quiet = 0;
	logic [63:0] tnow = 0;

	function automatic bit any_on();
		for (int i = 0; i < NSLOT; i++)
			if (t_act[i]) return 1;
		return 0;
	endfunction

	function automatic bit earlier(int a, int b);
		if (t_dl[a] != t_dl[b]) return t_dl[a] < t_dl[b];
		return a < b;
	endfunction

	function automatic int first_active();
		int best;
		best = -1;
		for (int i = 0; i < NSLOT; i++)
			if (t_act[i] && (best < 0 || earlier(i, best))) best = i;
		return best;
	endfunction

	function automatic logic front_hit(int s);
		if (first_active() == s && !t_notice) begin
			t_notice = 1;
			return 1;
		end
		return 0;
	endfunction

	function automatic void apply_cmd(cmd_t c);
		res_t r;
		int f, best, n;
		int order[16];
		bit taken[NSLOT];
		bit roll;
		logic [63:0] start;
		r = '0;
		r.last = 1;
		case (c.op)
			dotu_pkg::OP_ADD: begin
				f = -1;
				for (int i = 0; i < NSLOT; i++)
					if (!t_act[i] && f < 0) f = i;
				if (f < 0) begin
					r.status = dotu_pkg::ST_FULL;
				end else begin
					t_act[f] = 1;
					t_rec[f] = c.rec;
					t_per[f] = c.per;
					t_wr[f] = 1;
					t_dl[f] = c.now + 64'(c.per);
					r.rslot = 4'(f);
					r.fnote = front_hit(f);
				end
			end
			dotu_pkg::OP_CANCEL: begin
				if (t_act[c.slot]) t_act[c.slot] = 0;
				else r.status = dotu_pkg::ST_MISS;
			end
			dotu_pkg::OP_REFRESH: begin
				if (t_act[c.slot]) t_dl[c.slot] = c.now + 64'(t_per[c.slot]);
				else r.status = dotu_pkg::ST_MISS;
			end
			dotu_pkg::OP_RESET: begin
				if (!c.fnow && c.per == t_per[c.slot]) begin
					r.status = dotu_pkg::ST_OK;
				end else if (!t_act[c.slot]) begin
					r.status = dotu_pkg::ST_MISS;
				end else begin
					start = c.fnow ? c.now : t_dl[c.slot] - 64'(t_per[c.slot]);
					t_per[c.slot] = c.per;
					t_dl[c.slot] = start + 64'(c.per);
					r.fnote = front_hit(c.slot);
				end
			end
			dotu_pkg::OP_COLLECT: begin
				if (any_on()) begin
					roll = c.now < t_prev && (t_prev - c.now) > 64'(t_window);
					t_prev = c.now;
					f = first_active();
					if (roll || t_dl[f] <= c.now) begin
						n = 0;
						for (int i = 0; i < NSLOT; i++) taken[i] = 0;
						while (n < dotu_pkg::MAX_RESULTS) begin
							best = -1;
							for (int i = 0; i < NSLOT; i++)
								if (t_act[i] && !taken[i] && (roll || t_dl[i] <= c.now)
										&& (best < 0 || earlier(i, best)))
									best = i;
							if (best < 0) break;
							taken[best] = 1;
							order[n] = best;
							n++;
						end
						for (int k = 0; k < n; k++)
							if (t_rec[order[k]]) t_dl[order[k]] = c.now + 64'(t_per[order[k]]);
							else t_act[order[k]] = 0;
						for (int k = 0; k < n; k++) begin
							r = '0;
							r.rslot = 4'(order[k]);
							r.ev = 1;
							r.any = any_on();
							r.last = (k == n - 1);
							want_rsp.insert(want_rsp.size(), r);
						end
						return;
					end
				end
			end
			dotu_pkg::OP_QUERY: begin
				t_notice = 0;
				f = first_active();
				if (f < 0) r.ttn = dotu_pkg::ALL_ONES;
				else if (c.now >= t_dl[f]) r.ttn = '0;
				else r.ttn = t_dl[f] - c.now;
			end
			default: ;
		endcase
		r.any = any_on();
		want_rsp.insert(want_rsp.size(), r);
	endfunction

	task automatic push_cmd(logic [2:0] op, logic [3:0] s, logic [31:0] per,
			logic rec, logic fnow, logic [63:0] now);
		cmd_t c;
		c = '{op, s, per, rec, fnow, now};
		apply_cmd(c);
		pend_cmds.insert(pend_cmds.size(), c);
	endtask

	task automatic push_random();
		int r, s, act_cnt;
		logic [31:0] per;
		logic fnow;
		r = $urandom_range(99);
		if (r < 85) tnow += $urandom_range(0, 40);
		else if (r < 90) tnow -= $urandom_range(0, 2000);
		else if (r < 94) tnow -= 64'($urandom) + 1;
		else if (r < 97) tnow = {$urandom, $urandom};
		else tnow += 64'($urandom);
		per = ($urandom_range(99) < 85) ? $urandom_range(0, 120) : $urandom;
		s = $urandom_range(15);
		act_cnt = 0;
		for (int i = 0; i < NSLOT; i++) if (t_act[i]) act_cnt++;
		if (act_cnt > 0 && $urandom_range(99) < 80)
			do s = $urandom_range(15); while (!t_act[s]);
		fnow = 1'($urandom_range(1));
		r = $urandom_range(99);
		if (r < 27) begin
			push_cmd(dotu_pkg::OP_ADD, 4'($urandom), per, 1'($urandom_range(1)),
				1'($urandom_range(1)), tnow);
		end else if (r < 37) begin
			push_cmd(dotu_pkg::OP_CANCEL, 4'(s), $urandom, 1'($urandom_range(1)),
				1'($urandom_range(1)), tnow);
		end else if (r < 47) begin
			push_cmd(dotu_pkg::OP_REFRESH, 4'(s), $urandom, 1'($urandom_range(1)),
				1'($urandom_range(1)), tnow);
		end else if (r < 62) begin
			if (t_wr[s] && $urandom_range(3) == 0) per = t_per[s];
			if (!t_wr[s]) fnow = 1;
			push_cmd(dotu_pkg::OP_RESET, 4'(s), per, 1'($urandom_range(1)), fnow, tnow);
		end else if (r < 85) begin
			push_cmd(dotu_pkg::OP_COLLECT, 4'($urandom), $urandom, 1'($urandom_range(1)),
				1'($urandom_range(1)), tnow);
		end else if (r < 97) begin
			push_cmd(dotu_pkg::OP_QUERY, 4'($urandom), $urandom, 1'($urandom_range(1)),
				1'($urandom_range(1)), tnow);
		end else begin
			push_cmd(3'($urandom_range(6, 7)), 4'($urandom), $urandom,
				1'($urandom_range(1)), 1'($urandom_range(1)), tnow);
		end
	endtask

	task automatic write_window(logic [31:0] v);
		@(posedge clk);
		psel <= 1;
		pwrite <= 1;
		paddr <= dotu_pkg::ADDR_WINDOW;
		pwdata <= v;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		t_window = v;
	endtask

	task automatic drain();
		wait (pend_cmds.size() == 0 && want_rsp.size() == 0);
		repeat (40) @(posedge clk);
	endtask

	// command driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid <= 0;
		end else begin
			if (cmd_valid && !cmd_stall) n_cmds++;
			if (!(cmd_valid && cmd_stall)) begin
				if (pend_cmds.size() > 0 && $urandom_range(99) >= send_idle) begin
					cur = pend_cmds.pop_front();
					cmd_valid <= 1;
					opcode <= cur.op;
					slot <= cur.slot;
					period_ms <= cur.per;
					recurring <= cur.rec;
					restart_now <= cur.fnow;
					now_ms <= cur.now;
				end else begin
					cmd_valid <= 0;
				end
			end
		end
	end

	// result monitor and watchdog
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 0;
		end else begin
			rsp_stall <= ($urandom_range(99) < recv_idle);
			if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall)
					|| (pend_cmds.size() == 0 && want_rsp.size() == 0))
				quiet <= 0;
			else
				quiet <= quiet + 1;
			if (quiet >= STALL_LIMIT) begin
				$display("timeout: %0d results still expected", want_rsp.size());
				$display("Verification failed");
				$finish;
			end
			if (rsp_valid && !rsp_stall) begin
				n_rsp++;
				if (expired_valid) n_expired++;
				if (want_rsp.size() == 0) begin
					n_bad++;
					if (n_bad <= 10) $display("unexpected result transfer slot %0d", result_slot);
				end else begin
					res_t e, a;
					e = want_rsp.pop_front();
					a = '{status, result_slot, expired_valid, time_to_next, front_notice,
						any_active, last};
					if (a !== e) begin
						n_bad++;
						if (n_bad <= 10)
							$display({"mismatch: exp st=%0d slot=%0d ev=%0b ttn=%h fn=%0b any=%0b",
								" last=%0b / got st=%0d slot=%0d ev=%0b ttn=%h fn=%0b any=%0b",
								" last=%0b"}, e.status, e.rslot, e.ev, e.ttn, e.fnote, e.any,
								e.last, a.status, a.rslot, a.ev, a.ttn, a.fnote, a.any, a.last);
					end
				end
			end
		end
	end

	initial begin
		for (int i = 0; i < NSLOT; i++) begin
			t_act[i] = 0;
			t_rec[i] = 0;
			t_wr[i] = 0;
			t_per[i] = '0;
			t_dl[i] = '0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1;
		send_idle = 7;
		recv_idle = 67;

		push_cmd(dotu_pkg::OP_ADD, 4'd0, 32'd0, 1'b0, 1'b0, 64'd100);
		push_cmd(dotu_pkg::OP_ADD, 4'd0, 32'hFFFF_FFFF, 1'b1, 1'b0, 64'd100);
		push_cmd(dotu_pkg::OP_QUERY, 4'd0, 32'd0, 1'b0, 1'b0, 64'd50);
		push_cmd(dotu_pkg::OP_ADD, 4'd0, 32'd10, 1'b0, 1'b0, 64'd100);
		push_cmd(dotu_pkg::OP_RESET, 4'd2, 32'd10, 1'b0, 1'b0, 64'd100);
		push_cmd(dotu_pkg::OP_RESET, 4'd2, 32'd5, 1'b0, 1'b1, 64'd100);
		push_cmd(dotu_pkg::OP_REFRESH, 4'd0, 32'd0, 1'b0, 1'b0, 64'd200);
		push_cmd(dotu_pkg::OP_CANCEL, 4'd5, 32'd0, 1'b0, 1'b0, 64'd200);
		push_cmd(dotu_pkg::OP_REFRESH, 4'd5, 32'd0, 1'b0, 1'b0, 64'd200);
		push_cmd(dotu_pkg::OP_RESET, 4'd5, 32'd7, 1'b0, 1'b1, 64'd200);
		push_cmd(3'd6, 4'd15, 32'hFFFF_FFFF, 1'b1, 1'b1, dotu_pkg::ALL_ONES);
		push_cmd(3'd7, 4'd0, 32'd0, 1'b0, 1'b0, 64'd0);
		push_cmd(dotu_pkg::OP_COLLECT, 4'd0, 32'd0, 1'b0, 1'b0, 64'd150);
		push_cmd(dotu_pkg::OP_COLLECT, 4'd0, 32'd0, 1'b0, 1'b0, 64'd50);
		push_cmd(dotu_pkg::OP_CANCEL, 4'd0, 32'd0, 1'b0, 1'b0, 64'd60);
		push_cmd(dotu_pkg::OP_CANCEL, 4'd1, 32'd0, 1'b0, 1'b0, 64'd60);
		push_cmd(dotu_pkg::OP_COLLECT, 4'd0, 32'd0, 1'b0, 1'b0, 64'd70);
		push_cmd(dotu_pkg::OP_QUERY, 4'd0, 32'd0, 1'b0, 1'b0, 64'd70);
		for (int i = 0; i < NSLOT; i++)
			push_cmd(dotu_pkg::OP_ADD, 4'd0, 32'h20, i[0], 1'b0, 64'hFFFF_FFFF_FFFF_FFF0);
		push_cmd(dotu_pkg::OP_ADD, 4'd0, 32'd1, 1'b0, 1'b0, 64'd0);
		push_cmd(dotu_pkg::OP_COLLECT, 4'd0, 32'd0, 1'b0, 1'b0, 64'h10);
		tnow = 64'h10;
		drain();

		write_window(32'd0);
		repeat (90) push_random();
		drain();

		send_idle = 67;
		recv_idle = 7;
		write_window(32'hFFFF_FFFF);
		repeat (90) push_random();
		drain();

		send_idle = 0;
		recv_idle = 0;
		write_window($urandom_range(0, 2000));
		repeat (95) push_random();
		drain();

		$display("%0d commands sent, %0d results checked, %0d expiries, 4 window settings",
			n_cmds, n_rsp, n_expired);
		if (n_bad == 0) begin
			$display("Verification passed");
		end else begin
			$display("%0d mismatches", n_bad);
			$display("Verification failed");
		end
		$finish;
	end

endmodule

### filelist.f
+incdir+rtl
rtl/dotu_pkg.sv
rtl/dotu_ram.sv
rtl/dotu_alu.sv
rtl/deadline_ordered_timer_table_unit.sv
rtl/dotu_checker.sv
test/tb.sv
